// ===== hw/rtl/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants, status codes and arithmetic unit operations for the
// first-fit aligned allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int FREE_SLOTS_DEF  = 32;
    localparam int OWNED_SLOTS_DEF = 64;
    localparam int ADDR_BITS_DEF   = 28;

    localparam longint unsigned REGION_RESET = 64'd268435456;

    localparam int CALC_W_DEF = ((ADDR_BITS_DEF + 1 > 32) ? ADDR_BITS_DEF + 1 : 32) + 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_NOTOWN = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef enum logic [1:0] {
        CALC_ADD,
        CALC_SUB,
        CALC_ALIGN
    } t_calc_op;

endpackage

// ===== hw/rtl/ffa_ram.sv =====
// ----------------------------------------------------------------------------
// ffa_ram
// Simple dual-port table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffa_ram
    import ffa_pkg::*;
#(
    parameter int WIDTH = CALC_W_DEF,
    parameter int DEPTH = FREE_SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ffa_calc.sv =====
// ----------------------------------------------------------------------------
// ffa_calc
// Shared adder for the fit test: add, subtract with borrow-out compare, and
// round-up to an alignment mask.
// ----------------------------------------------------------------------------
module ffa_calc
    import ffa_pkg::*;
#(
    parameter int CALC_W = CALC_W_DEF
) (
    input  t_calc_op          i_op,
    input  logic [CALC_W-1:0] i_x,
    input  logic [CALC_W-1:0] i_y,
    output logic [CALC_W-1:0] o_res,
    output logic              o_ge
);

    logic [CALC_W-1:0] y_eff;
    logic              cin;
    logic [CALC_W:0]   sum;

    always_comb begin
        y_eff = i_y;
        cin   = 1'b0;
        case (i_op)
            CALC_SUB: begin
                y_eff = ~i_y;
                cin   = 1'b1;
            end
            default: begin
                y_eff = i_y;
                cin   = 1'b0;
            end
        endcase
        sum = {1'b0, i_x} + {1'b0, y_eff} + (CALC_W+1)'(cin);
    end

    always_comb begin
        case (i_op)
            CALC_ALIGN: o_res = sum[CALC_W-1:0] & ~i_y;
            default:    o_res = sum[CALC_W-1:0];
        endcase
    end

    assign o_ge = sum[CALC_W];

endmodule

// ===== hw/rtl/first_fit_aligned_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_aligned_allocator_unit
// First-fit allocator over one region: free-run list scanned in table order, owned table,
// aligned allocate and non-merging free, driven by a small sequencer.
// ----------------------------------------------------------------------------
// Allocate: each free run scanned takes a read plus four passes through the
//   shared adder, then an update on a fit and a read and write per run moved when an exact fit removes a run.
// Free: a read and compare per owned record scanned, a read and write per record moved, then an append.
// Owned-table-full and empty-table answers come straight from idle; the result strobe
//   comes in the cycle after the last step and busy is low again in that cycle.
// Reset and a region write leave one free run and an empty owned table at once.
// ----------------------------------------------------------------------------
module first_fit_aligned_allocator_unit
    import ffa_pkg::*;
#(
    parameter int FREE_SLOTS  = FREE_SLOTS_DEF,
    parameter int OWNED_SLOTS = OWNED_SLOTS_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_opcode,
    input  logic [ADDR_BITS:0]   i_req_size,
    input  logic [4:0]           i_align_log2,
    input  logic [ADDR_BITS-1:0] i_free_offset,
    input  logic                 i_cfg_we,
    input  logic [ADDR_BITS:0]   i_cfg_wdata,
    output logic                 o_done,
    output logic [1:0]           o_status,
    output logic [ADDR_BITS-1:0] o_alloc_offset
);

    localparam int LW  = ADDR_BITS + 1;
    localparam int CW  = ((LW > 32) ? LW : 32) + 2;
    localparam int FIW = $clog2(FREE_SLOTS);
    localparam int FCW = $clog2(FREE_SLOTS + 1);
    localparam int OIW = $clog2(OWNED_SLOTS);
    localparam int OCW = $clog2(OWNED_SLOTS + 1);
    localparam int FRW = 2 * LW;
    localparam int OWW = ADDR_BITS + LW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_RD,
        S_A_ALN,
        S_A_END,
        S_A_EXT,
        S_A_CMP,
        S_A_UPD,
        S_R_RD,
        S_R_WR,
        S_F_RD,
        S_F_CMP,
        S_O_RD,
        S_O_WR,
        S_F_APP
    } t_state;

    t_state               r_state;
    logic [LW-1:0]        r_region;
    logic [FCW-1:0]       r_run_cnt;
    logic [OCW-1:0]       r_own_cnt;
    logic                 r_run0_init;
    logic                 r_rd0;
    logic [FIW-1:0]       r_fi;
    logic [OIW-1:0]       r_oi;
    logic [LW-1:0]        r_size;
    logic [4:0]           r_lg;
    logic [ADDR_BITS-1:0] r_ofs;
    logic [CW-1:0]        r_a;
    logic [CW-1:0]        r_aend;
    logic [CW-1:0]        r_e;
    logic [LW-1:0]        r_nlen;
    logic                 r_done;
    logic [1:0]           r_status;
    logic [ADDR_BITS-1:0] r_offset;

    logic                 free_we;
    logic [FIW-1:0]       free_waddr;
    logic [FRW-1:0]       free_wdata;
    logic                 free_re;
    logic [FIW-1:0]       free_raddr;
    logic [FRW-1:0]       free_rdata;

    logic                 own_we;
    logic [OIW-1:0]       own_waddr;
    logic [OWW-1:0]       own_wdata;
    logic                 own_re;
    logic [OIW-1:0]       own_raddr;
    logic [OWW-1:0]       own_rdata;

    t_calc_op             calc_op;
    logic [CW-1:0]        calc_x;
    logic [CW-1:0]        calc_y;
    logic [CW-1:0]        calc_res;
    logic                 calc_ge;

    logic [LW-1:0]        run_s;
    logic [LW-1:0]        run_len;
    logic [CW-1:0]        align_mask;
    logic                 exact;
    logic                 own_match;
    logic [FCW-1:0]       fi_nxt;
    logic [FCW-1:0]       fi_nxt2;
    logic [OCW-1:0]       oi_nxt;
    logic [OCW-1:0]       oi_nxt2;

    ffa_ram #(
        .WIDTH (FRW),
        .DEPTH (FREE_SLOTS)
    ) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (free_we),
        .i_waddr (free_waddr),
        .i_wdata (free_wdata),
        .i_re    (free_re),
        .i_raddr (free_raddr),
        .o_rdata (free_rdata)
    );

    ffa_ram #(
        .WIDTH (OWW),
        .DEPTH (OWNED_SLOTS)
    ) u_own_ram (
        .i_clk   (i_clk),
        .i_we    (own_we),
        .i_waddr (own_waddr),
        .i_wdata (own_wdata),
        .i_re    (own_re),
        .i_raddr (own_raddr),
        .o_rdata (own_rdata)
    );

    ffa_calc #(
        .CALC_W (CW)
    ) u_calc (
        .i_op  (calc_op),
        .i_x   (calc_x),
        .i_y   (calc_y),
        .o_res (calc_res),
        .o_ge  (calc_ge)
    );

    assign run_s      = r_rd0 ? '0 : free_rdata[FRW-1:LW];
    assign run_len    = r_rd0 ? r_region : free_rdata[LW-1:0];
    assign align_mask = ~({CW{1'b1}} << r_lg);
    assign exact      = (run_len == r_size);
    assign own_match  = (own_rdata[OWW-1:LW] == r_ofs) && (own_rdata[LW-1:0] == r_size);
    assign fi_nxt     = FCW'(r_fi) + FCW'(1);
    assign fi_nxt2    = fi_nxt + FCW'(1);
    assign oi_nxt     = OCW'(r_oi) + OCW'(1);
    assign oi_nxt2    = oi_nxt + OCW'(1);

    always_comb begin
        calc_op = CALC_ADD;
        calc_x  = '0;
        calc_y  = '0;
        case (r_state)
            S_A_ALN: begin
                calc_op = CALC_ALIGN;
                calc_x  = CW'(run_s);
                calc_y  = align_mask;
            end
            S_A_END: begin
                calc_op = CALC_ADD;
                calc_x  = r_a;
                calc_y  = CW'(r_size);
            end
            S_A_EXT: begin
                calc_op = CALC_ADD;
                calc_x  = CW'(run_s);
                calc_y  = CW'(run_len);
            end
            S_A_CMP: begin
                calc_op = CALC_SUB;
                calc_x  = r_e;
                calc_y  = r_aend;
            end
            default: begin
                calc_op = CALC_ADD;
                calc_x  = '0;
                calc_y  = '0;
            end
        endcase
    end

    always_comb begin
        free_we    = 1'b0;
        free_waddr = r_fi;
        free_wdata = free_rdata;
        free_re    = 1'b0;
        free_raddr = r_fi;
        own_we     = 1'b0;
        own_waddr  = r_oi;
        own_wdata  = own_rdata;
        own_re     = 1'b0;
        own_raddr  = r_oi;
        case (r_state)
            S_A_RD: begin
                free_re = 1'b1;
            end
            S_A_UPD: begin
                free_we    = !exact;
                free_wdata = {r_aend[LW-1:0], r_nlen};
                own_we     = 1'b1;
                own_waddr  = r_own_cnt[OIW-1:0];
                own_wdata  = {r_a[ADDR_BITS-1:0], r_size};
            end
            S_R_RD: begin
                free_re    = 1'b1;
                free_raddr = r_fi + FIW'(1);
            end
            S_R_WR: begin
                free_we = 1'b1;
            end
            S_F_RD: begin
                own_re = 1'b1;
            end
            S_O_RD: begin
                own_re    = 1'b1;
                own_raddr = r_oi + OIW'(1);
            end
            S_O_WR: begin
                own_we = 1'b1;
            end
            S_F_APP: begin
                free_we    = 1'b1;
                free_waddr = r_run_cnt[FIW-1:0];
                free_wdata = {LW'(r_ofs), r_size};
            end
            default: begin
                free_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_region    <= LW'(REGION_RESET);
            r_run_cnt   <= FCW'(1);
            r_own_cnt   <= '0;
            r_run0_init <= 1'b1;
            r_rd0       <= 1'b0;
            r_done      <= 1'b0;
            r_status    <= ST_OK;
            r_offset    <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_size <= i_req_size;
                        r_lg   <= i_align_log2;
                        r_ofs  <= i_free_offset;
                        r_fi   <= '0;
                        r_oi   <= '0;
                        if (i_opcode == OP_ALLOC) begin
                            if (r_own_cnt >= OCW'(OWNED_SLOTS)) begin
                                r_done   <= 1'b1;
                                r_status <= ST_FULL;
                                r_offset <= '0;
                            end else if (r_run_cnt == '0) begin
                                r_done   <= 1'b1;
                                r_status <= ST_NOFIT;
                                r_offset <= '0;
                            end else begin
                                r_state <= S_A_RD;
                            end
                        end else begin
                            if (r_own_cnt == '0) begin
                                r_done   <= 1'b1;
                                r_status <= ST_NOTOWN;
                                r_offset <= '0;
                            end else begin
                                r_state <= S_F_RD;
                            end
                        end
                    end
                end
                S_A_RD: begin
                    r_rd0   <= (r_fi == '0) && r_run0_init;
                    r_state <= S_A_ALN;
                end
                S_A_ALN: begin
                    r_a     <= calc_res;
                    r_state <= S_A_END;
                end
                S_A_END: begin
                    r_aend  <= calc_res;
                    r_state <= S_A_EXT;
                end
                S_A_EXT: begin
                    r_e     <= calc_res;
                    r_state <= S_A_CMP;
                end
                S_A_CMP: begin
                    if (calc_ge) begin
                        r_nlen  <= calc_res[LW-1:0];
                        r_state <= S_A_UPD;
                    end else if (fi_nxt < r_run_cnt) begin
                        r_fi    <= r_fi + FIW'(1);
                        r_state <= S_A_RD;
                    end else begin
                        r_done   <= 1'b1;
                        r_status <= ST_NOFIT;
                        r_offset <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                S_A_UPD: begin
                    r_own_cnt <= r_own_cnt + OCW'(1);
                    r_offset  <= r_a[ADDR_BITS-1:0];
                    r_status  <= ST_OK;
                    if (exact && (fi_nxt < r_run_cnt)) begin
                        r_state <= S_R_RD;
                    end else begin
                        if (exact) begin
                            r_run_cnt <= r_run_cnt - FCW'(1);
                        end else if (r_fi == '0) begin
                            r_run0_init <= 1'b0;
                        end
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_R_RD: begin
                    r_state <= S_R_WR;
                end
                S_R_WR: begin
                    if (r_fi == '0) begin
                        r_run0_init <= 1'b0;
                    end
                    r_fi <= r_fi + FIW'(1);
                    if (fi_nxt2 < r_run_cnt) begin
                        r_state <= S_R_RD;
                    end else begin
                        r_run_cnt <= r_run_cnt - FCW'(1);
                        r_done    <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                S_F_RD: begin
                    r_state <= S_F_CMP;
                end
                S_F_CMP: begin
                    if (own_match) begin
                        if (r_run_cnt >= FCW'(FREE_SLOTS)) begin
                            r_done   <= 1'b1;
                            r_status <= ST_FULL;
                            r_offset <= '0;
                            r_state  <= S_IDLE;
                        end else if (oi_nxt < r_own_cnt) begin
                            r_state <= S_O_RD;
                        end else begin
                            r_state <= S_F_APP;
                        end
                    end else if (oi_nxt < r_own_cnt) begin
                        r_oi    <= r_oi + OIW'(1);
                        r_state <= S_F_RD;
                    end else begin
                        r_done   <= 1'b1;
                        r_status <= ST_NOTOWN;
                        r_offset <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                S_O_RD: begin
                    r_state <= S_O_WR;
                end
                S_O_WR: begin
                    r_oi <= r_oi + OIW'(1);
                    if (oi_nxt2 < r_own_cnt) begin
                        r_state <= S_O_RD;
                    end else begin
                        r_state <= S_F_APP;
                    end
                end
                S_F_APP: begin
                    if (r_run_cnt == '0) begin
                        r_run0_init <= 1'b0;
                    end
                    r_own_cnt <= r_own_cnt - OCW'(1);
                    r_run_cnt <= r_run_cnt + FCW'(1);
                    r_done    <= 1'b1;
                    r_status  <= ST_OK;
                    r_offset  <= '0;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_we) begin
                r_region    <= i_cfg_wdata;
                r_run_cnt   <= FCW'(1);
                r_own_cnt   <= '0;
                r_run0_init <= 1'b1;
            end
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_alloc_offset = r_offset;

    a_run_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_cnt <= FCW'(FREE_SLOTS))
        else $error("free run count above table depth");

    a_own_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_own_cnt <= OCW'(OWNED_SLOTS))
        else $error("owned count above table depth");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while sequencer active");

    a_start_reacts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && start && !busy) |=> (busy || o_done))
        else $error("accepted transfer neither started nor answered");

    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_OK)) |-> (o_alloc_offset == '0))
        else $error("nonzero offset on failed request");

endmodule
